// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication on clk_i, disabled while rst_ni is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hdbn_pkg.sv =====
// ---------------------------------------------------------------------------
// HDBn package
// Symbol codes and order limits of the HDBn line encoder.
// ---------------------------------------------------------------------------
package hdbn_pkg;

  typedef logic [1:0] sym_t;

  localparam sym_t SYM_ZERO = 2'd0;
  localparam sym_t SYM_POS  = 2'd1;
  localparam sym_t SYM_NEG  = 2'd2;

  localparam int unsigned ORDER_W     = 3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
  localparam logic [ORDER_W-1:0] MIN_ORDER   = 3'd2;

endpackage

// ===== hw/rtl/hdbn_if.sv =====
// ---------------------------------------------------------------------------
// HDBn channel interfaces
// Valid/ready channels for input bits and encoded symbols.
// ---------------------------------------------------------------------------
interface hdbn_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_in;

  modport source (output valid, output data_bit, output last_in, input ready);
  modport sink (input valid, input data_bit, input last_in, output ready);
endinterface

interface hdbn_out_if;
  logic valid;
  logic ready;
  logic pos_pulse;
  logic neg_pulse;
  logic last_out;

  modport source (output valid, output pos_pulse, output neg_pulse, output last_out,
                  input ready);
  modport sink (input valid, input pos_pulse, input neg_pulse, input last_out,
                output ready);
endinterface

// ===== hw/rtl/hdbn_front.sv =====
// ---------------------------------------------------------------------------
// HDBn front end
// Classifies each bit into a symbol, keeps the delay line for balancing
// pulses and pushes the symbols that a bit releases as one bundle.
// ---------------------------------------------------------------------------
module hdbn_front #(
  parameter int unsigned MAX_ORDER = 4,
  parameter int unsigned CW        = $clog2(MAX_ORDER + 2),
  parameter int unsigned QW        = 2 * (MAX_ORDER + 1) + CW + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hdbn_pkg::ORDER_W-1:0]  cfg_wdata_i,
  hdbn_in_if.sink                       in_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic [QW-1:0]                 q_data_o
);
  import hdbn_pkg::*;

  localparam int unsigned D = MAX_ORDER + 1;

  logic [ORDER_W-1:0] order_q;
  sym_t               held_q [D];
  sym_t               held_d [D];
  sym_t               h      [D];
  logic [CW-1:0]      held_cnt_q, held_cnt_d;
  logic [CW-1:0]      zero_run_q, zero_run_d;
  logic               lmp_q, lmp_d;
  logic               lvp_q, lvp_d;

  logic [CW-1:0]      n;
  logic [CW-1:0]      zr_inc;
  logic [CW-1:0]      cnt1;
  logic [CW-1:0]      pops;
  logic               vpos;
  sym_t               sym;
  sym_t               vsym;
  logic [2*D-1:0]     syms_flat;
  logic               accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if (order_q < MIN_ORDER) begin
      n = CW'(MIN_ORDER);
    end else if (int'(order_q) > int'(MAX_ORDER)) begin
      n = CW'(MAX_ORDER);
    end else begin
      n = CW'(order_q);
    end
  end

  always_comb begin
    h          = held_q;
    lmp_d      = lmp_q;
    lvp_d      = lvp_q;
    zr_inc     = zero_run_q + CW'(1);
    zero_run_d = zr_inc;
    sym        = SYM_ZERO;
    vpos       = !lvp_q;
    vsym       = vpos ? SYM_POS : SYM_NEG;
    cnt1       = held_cnt_q + CW'(1);

    if (in_i.data_bit) begin
      zero_run_d = '0;
      sym        = lmp_q ? SYM_NEG : SYM_POS;
      lmp_d      = !lmp_q;
    end else if (zr_inc >= n + CW'(1)) begin
      sym = vsym;
      if ((lmp_q != vpos) && (held_cnt_q >= n)) begin
        for (int i = 0; i < D; i++) begin
          if (CW'(i) == held_cnt_q - n) begin
            h[i] = vsym;
          end
        end
        lmp_d = vpos;
      end
      lvp_d      = vpos;
      zero_run_d = '0;
    end

    for (int i = 0; i < D; i++) begin
      if (CW'(i) == held_cnt_q) begin
        h[i] = sym;
      end
    end

    if (in_i.last_in) begin
      pops = cnt1;
    end else if (cnt1 > n) begin
      pops = cnt1 - n;
    end else begin
      pops = '0;
    end

    for (int i = 0; i < D; i++) begin
      syms_flat[2*i +: 2] = h[i];
      held_d[i]           = SYM_ZERO;
      for (int j = 0; j < D; j++) begin
        if ((j >= i) && (CW'(j - i) == pops) && (CW'(j) < cnt1)) begin
          held_d[i] = h[j];
        end
      end
    end
    held_cnt_d = cnt1 - pops;

    if (in_i.last_in) begin
      for (int i = 0; i < D; i++) begin
        held_d[i] = SYM_ZERO;
      end
      held_cnt_d = '0;
      zero_run_d = '0;
      lmp_d      = 1'b0;
      lvp_d      = 1'b0;
    end
  end

  assign q_push_o = accept && (pops != '0);
  assign q_data_o = {in_i.last_in, pops, syms_flat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q    <= ORDER_RESET;
      held_cnt_q <= '0;
      zero_run_q <= '0;
      lmp_q      <= 1'b0;
      lvp_q      <= 1'b0;
      for (int i = 0; i < D; i++) begin
        held_q[i] <= SYM_ZERO;
      end
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (accept) begin
        held_q     <= held_d;
        held_cnt_q <= held_cnt_d;
        zero_run_q <= zero_run_d;
        lmp_q      <= lmp_d;
        lvp_q      <= lvp_d;
      end
    end
  end

endmodule

// ===== hw/rtl/hdbn_queue.sv =====
// ---------------------------------------------------------------------------
// HDBn bundle queue
// Small FIFO between the front end and the symbol sender.
// ---------------------------------------------------------------------------
module hdbn_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/hdbn_back.sv =====
// ---------------------------------------------------------------------------
// HDBn back end
// Unpacks queued bundles and sends one symbol per transfer through a
// registered output stage.
// ---------------------------------------------------------------------------
module hdbn_back #(
  parameter int unsigned MAX_ORDER = 4,
  parameter int unsigned CW        = $clog2(MAX_ORDER + 2),
  parameter int unsigned QW        = 2 * (MAX_ORDER + 1) + CW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  logic [QW-1:0] q_data_i,
  output logic          q_pop_o,
  hdbn_out_if.source    out_o
);
  import hdbn_pkg::*;

  localparam int unsigned D  = MAX_ORDER + 1;
  localparam int unsigned SW = 2 * D;
  localparam int unsigned IW = $clog2(D);

  logic [SW-1:0] syms_flat;
  logic [CW-1:0] cnt;
  logic          bundle_last;
  logic [IW-1:0] idx_q;
  sym_t          sym;
  logic          is_end;
  logic          take;
  logic          valid_q, pos_q, neg_q, last_q;

  assign syms_flat   = q_data_i[SW-1:0];
  assign cnt         = q_data_i[SW +: CW];
  assign bundle_last = q_data_i[SW+CW];

  assign sym     = syms_flat[2*idx_q +: 2];
  assign is_end  = ((CW'(idx_q) + CW'(1)) == cnt);
  assign take    = q_valid_i && (!valid_q || out_o.ready);
  assign q_pop_o = take && is_end;

  assign out_o.valid     = valid_q;
  assign out_o.pos_pulse = pos_q;
  assign out_o.neg_pulse = neg_q;
  assign out_o.last_out  = last_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      pos_q  <= (sym == SYM_POS);
      neg_q  <= (sym == SYM_NEG);
      last_q <= bundle_last && is_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        idx_q   <= is_end ? '0 : idx_q + IW'(1);
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/hdbn_line_encoder.sv =====
// HDBn line encoder: while the queue has room and out_o is ready, one
// message bit is taken on in_i and one bipolar symbol leaves on out_o per
// clock. Symbols appear after a delay of n bits (n = order register,
// clamped to 2..MAX_ORDER) via the bundle queue and the output register.
// A bit flagged last releases up to n+1 symbols, sent one per cycle while
// out_o is ready; input is held off only while the two-entry queue is full.
// Write the order register only while the encoder is idle.
// ---------------------------------------------------------------------------
// HDBn line encoder top level
// Front end, bundle queue and symbol sender.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbn_line_encoder #(
  parameter int unsigned MAX_ORDER = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hdbn_pkg::ORDER_W-1:0]  cfg_wdata_i,
  hdbn_in_if.sink                       in_i,
  hdbn_out_if.source                    out_o
);
  import hdbn_pkg::*;

  localparam int unsigned CW      = $clog2(MAX_ORDER + 2);
  localparam int unsigned QW      = 2 * (MAX_ORDER + 1) + CW + 1;
  localparam int unsigned Q_DEPTH = 2;

  logic          q_push, q_pop, q_full, q_valid;
  logic [QW-1:0] q_wdata, q_rdata;

  hdbn_front #(
    .MAX_ORDER (MAX_ORDER),
    .CW        (CW),
    .QW        (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  hdbn_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  hdbn_back #(
    .MAX_ORDER (MAX_ORDER),
    .CW        (CW),
    .QW        (QW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  `ASSERT_IMPL(a_pulse_excl, out_o.valid, !(out_o.pos_pulse && out_o.neg_pulse), "both pulses set")
  `ASSERT_IMPL(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  `ASSERT_IMPL(a_push_room, q_push, !q_full, "push into full queue")
  `ASSERT_CLK(a_push_on_accept, !q_push || (in_i.valid && in_i.ready), "push without transfer")

endmodule

// ===== bench/tb_hdbn_line_encoder.sv =====
// ---------------------------------------------------------------------------
// HDBn line encoder testbench
// Drives message bits through the input channel with random gaps and checks
// every symbol transfer against a local HDBn encoder model. Covers order
// settings including clamped values, order changes inside a message, drain
// on the last bit, and long output back-pressure.
// ---------------------------------------------------------------------------
module tb_hdbn_line_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hdbn_pkg::*;

  localparam int unsigned MAX_ORDER = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic pos;
    logic neg;
    logic fin;
  } line_sym_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [ORDER_W-1:0] cfg_wdata;

  hdbn_in_if  in_ch();
  hdbn_out_if out_ch();

  hdbn_line_encoder #(
    .MAX_ORDER(MAX_ORDER)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // encoder model state
  logic [ORDER_W-1:0] order_q;
  sym_t held_sym[MAX_ORDER+1];
  int unsigned held_n;
  int unsigned zero_run;
  logic mark_pos;
  logic viol_pos;
  line_sym_t expected_syms[$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int unsigned rx_hold = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[hdbn_line_encoder] ERROR");
      $finish;
    end
  end

  function automatic void clear_message();
    int i;
    for (i = 0; i <= MAX_ORDER; i++) held_sym[i] = SYM_ZERO;
    held_n = 0;
    zero_run = 0;
    mark_pos = 1'b0;
    viol_pos = 1'b0;
  endfunction

  function automatic sym_t pop_held();
    sym_t s;
    int unsigned i;
    s = held_sym[0];
    for (i = 1; i < held_n; i++) held_sym[i-1] = held_sym[i];
    held_n--;
    held_sym[held_n] = SYM_ZERO;
    return s;
  endfunction

  function automatic void push_symbol(sym_t s, logic fin);
    expected_syms.push_back(line_sym_t'{pos: (s == SYM_POS), neg: (s == SYM_NEG), fin: fin});
  endfunction

  function automatic void encode_bit(logic d, logic fin);
    int unsigned n;
    sym_t s;
    logic vpos;
    if (int'(order_q) < int'(MIN_ORDER)) n = int'(MIN_ORDER);
    else if (int'(order_q) > int'(MAX_ORDER)) n = MAX_ORDER;
    else n = int'(order_q);

    if (d) begin
      zero_run = 0;
      s = mark_pos ? SYM_NEG : SYM_POS;
      mark_pos = !mark_pos;
    end else begin
      zero_run++;
      if (zero_run >= n + 1) begin
        vpos = !viol_pos;
        s = vpos ? SYM_POS : SYM_NEG;
        // balancing pulse n positions back
        if (mark_pos != vpos && held_n >= n) begin
          held_sym[held_n - n] = s;
          mark_pos = vpos;
        end
        viol_pos = vpos;
        zero_run = 0;
      end else begin
        s = SYM_ZERO;
      end
    end

    held_sym[held_n] = s;
    held_n++;

    if (fin) begin
      while (held_n > 0) begin
        s = pop_held();
        push_symbol(s, held_n == 0);
      end
      clear_message();
    end else begin
      while (held_n > n) push_symbol(pop_held(), 1'b0);
    end
  endfunction

  function automatic void check_field(string name, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0b, got %0b", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : symbol_check
    line_sym_t exp_s;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_syms.size() == 0) begin
        $error("symbol transfer with nothing expected: pos %0b neg %0b last %0b",
               out_ch.pos_pulse, out_ch.neg_pulse, out_ch.last_out);
        err_cnt++;
      end else begin
        exp_s = expected_syms.pop_front();
        check_field("pos_pulse", exp_s.pos, out_ch.pos_pulse);
        check_field("neg_pulse", exp_s.neg, out_ch.neg_pulse);
        check_field("last_out", exp_s.fin, out_ch.last_out);
      end
    end
  end

  // symbol sink: random stalls plus an optional long hold
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 10) : 0;
      stall += rx_hold;
      rx_hold = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid && rx_hold == 0);
    end
  end

  task automatic send_bit(logic d, logic fin);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.data_bit <= d;
    in_ch.last_in  <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    encode_bit(d, fin);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_syms.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    order_q = v;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pattern(logic [31:0] bits, int unsigned len, logic fin);
    int unsigned i;
    for (i = 0; i < len; i++) send_bit(bits[len-1-i], fin && (i == len - 1));
  endtask

  // HDB3 at reset: plain violation, balanced violation, single-bit message
  task automatic test_reset_order();
    send_pattern(32'b1_0000_0000_1, 10, 1'b0);
    send_pattern(32'b1_0000, 5, 1'b1);
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b1);
  endtask

  // clamped and extreme order values
  task automatic test_order_values();
    logic [ORDER_W-1:0] vals[4] = '{3'd0, 3'd7, 3'd2, 3'd4};
    int i;
    for (i = 0; i < 4; i++) begin
      wait_idle();
      write_order(vals[i]);
      send_pattern(32'b10_0000, 6, 1'b1);
    end
  endtask

  // order lowered and raised while symbols are held
  task automatic test_order_change_in_message();
    wait_idle();
    write_order(3'd4);
    send_pattern(32'b0000, 4, 1'b0);
    wait_idle();
    write_order(3'd2);
    send_pattern(32'b0100, 4, 1'b1);
    send_pattern(32'b100, 3, 1'b0);
    wait_idle();
    write_order(3'd4);
    send_pattern(32'b00000_1, 6, 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    wait_idle();
    write_order(3'd4);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold = 60;
    for (i = 0; i < 30; i++) send_bit(1'($urandom_range(0, 1)), (i % 7) == 6);
    send_bit(1'b0, 1'b1);
    wait_idle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    int unsigned zero_pct;
    int unsigned i;
    bit noise;
    logic fin;
    sent = 0;
    while (sent < 70) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_order(ORDER_W'($urandom_range(0, 7)));
      end
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      noise = ($urandom_range(0, 7) == 0);
      len = $urandom_range(1, 14);
      zero_pct = ($urandom_range(0, 3) == 0) ? 50 : 85;
      fin = ($urandom_range(0, 9) != 0);
      for (i = 0; i < len; i++) begin
        if (noise) send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else send_bit($urandom_range(0, 99) >= zero_pct, fin && (i == len - 1));
        sent++;
      end
    end
    send_bit(1'b0, 1'b1);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.data_bit <= 1'b0;
    in_ch.last_in  <= 1'b0;
    order_q = ORDER_RESET;
    clear_message();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_order();
    test_order_values();
    test_order_change_in_message();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[hdbn_line_encoder] OK");
    end else begin
      $display("[hdbn_line_encoder] ERROR");
    end
    $finish;
  end

endmodule
